// File: hw/rtl/csvs_pkg.sv
// Package for the CSV field splitter: transaction types, character codes,
// result kinds, default sizes and the command record passed from front to back.
// Depends on nothing; every other file of the block imports it.
package csvs_pkg;

    localparam int MAX_FIELDS_DEF = 32;
    localparam int HOLD_DEPTH_DEF = 16;
    localparam int HOLD_STORE     = 16;
    localparam int FIDX_W         = 5;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_MARK = 1'b1;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] data_byte;
        logic       end_of_line;
    } in_item_t;

    typedef struct packed {
        logic              kind;
        logic [7:0]        out_byte;
        logic [FIDX_W-1:0] field_index;
        logic              index_overflow;
        logic              space_overflow;
        logic              line_end;
        logic              last_of_run;
    } out_item_t;

    // One classified input item, as the back part carries it out.
    typedef struct packed {
        logic              op_char;
        logic              op_comma;
        logic              eol;
        logic [7:0]        ch;
        logic [FIDX_W-1:0] idx;
        logic              sat;
        logic [FIDX_W-1:0] eol_idx;
        logic              eol_sat;
    } cmd_t;

    typedef enum logic [1:0] {
        PH_BODY = 2'b01,
        PH_EOL  = 2'b10
    } phase_t;

endpackage

// File: hw/rtl/csvs_front.sv
// Front part of the CSV field splitter: accepts input transactions, tracks
// quote mode and the field counter, and turns each item into a command.
// Depends on csvs_pkg.
module csvs_front
    import csvs_pkg::*;
#(
    parameter int MAX_FIELDS = MAX_FIELDS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_stall,
    input  in_item_t item,
    input  logic     q_full,
    output logic     q_push,
    output cmd_t     q_cmd
);

    localparam int CNT_W = $clog2(MAX_FIELDS);

    logic             in_quotes_reg, in_quotes_next;
    logic             prev_quote_reg, prev_quote_next;
    logic [CNT_W-1:0] field_cnt_reg, field_cnt_next;
    logic             cnt_sat_reg, cnt_sat_next;

    logic             accept;
    logic             is_comma;
    logic             is_quote;
    logic             op_char;
    logic [CNT_W-1:0] cnt_after;
    logic             sat_after;
    logic [CNT_W+FIDX_W-1:0] idx_wide;
    logic [CNT_W+FIDX_W-1:0] eol_idx_wide;

    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;

    assign is_comma = item.has_byte && !in_quotes_reg && (item.data_byte == CH_COMMA);
    assign is_quote = item.has_byte && (item.data_byte == CH_QUOTE);
    // A quote that reopens quote mode right after a quote stands for a literal quote.
    assign op_char  = item.has_byte && !is_comma
                      && (!is_quote || (!in_quotes_reg && prev_quote_reg));

    always_comb
    begin
        cnt_after = field_cnt_reg;
        sat_after = cnt_sat_reg;
        if (is_comma)
        begin
            if (field_cnt_reg == CNT_W'(MAX_FIELDS - 1))
            begin
                sat_after = 1'b1;
            end
            else
            begin
                cnt_after = field_cnt_reg + 1'b1;
            end
        end
    end

    assign idx_wide     = {{FIDX_W{1'b0}}, field_cnt_reg};
    assign eol_idx_wide = {{FIDX_W{1'b0}}, cnt_after};

    always_comb
    begin
        q_cmd.op_char  = op_char;
        q_cmd.op_comma = is_comma;
        q_cmd.eol      = item.end_of_line;
        q_cmd.ch       = item.data_byte;
        q_cmd.idx      = idx_wide[FIDX_W-1:0];
        q_cmd.sat      = cnt_sat_reg;
        q_cmd.eol_idx  = eol_idx_wide[FIDX_W-1:0];
        q_cmd.eol_sat  = sat_after;
    end

    assign q_push = accept && (op_char || is_comma || item.end_of_line);

    always_comb
    begin
        in_quotes_next  = in_quotes_reg;
        prev_quote_next = prev_quote_reg;
        field_cnt_next  = field_cnt_reg;
        cnt_sat_next    = cnt_sat_reg;
        if (accept)
        begin
            if (item.has_byte)
            begin
                if (is_quote && !is_comma)
                begin
                    in_quotes_next  = !in_quotes_reg;
                    prev_quote_next = 1'b1;
                end
                else
                begin
                    prev_quote_next = 1'b0;
                end
            end
            field_cnt_next = cnt_after;
            cnt_sat_next   = sat_after;
            if (item.end_of_line)
            begin
                in_quotes_next  = 1'b0;
                prev_quote_next = 1'b0;
                field_cnt_next  = '0;
                cnt_sat_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quotes_reg  <= 1'b0;
            prev_quote_reg <= 1'b0;
            field_cnt_reg  <= '0;
            cnt_sat_reg    <= 1'b0;
        end
        else
        begin
            in_quotes_reg  <= in_quotes_next;
            prev_quote_reg <= prev_quote_next;
            field_cnt_reg  <= field_cnt_next;
            cnt_sat_reg    <= cnt_sat_next;
        end
    end

endmodule

// File: hw/rtl/csvs_queue.sv
// Short command queue between the front and back parts of the CSV splitter.
// Depends on csvs_pkg for the command record and the queue depth.
module csvs_queue
    import csvs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head
);

    localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t            entry_reg [QUEUE_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0] count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full       = (count_reg == QC_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hw/rtl/csvs_back.sv
// Back part of the CSV field splitter: trims whitespace, flushes held bytes,
// emits field bytes and field end markers through one output register.
// Depends on csvs_pkg.
module csvs_back
    import csvs_pkg::*;
#(
    parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      trim_enable,
    input  logic      head_valid,
    input  cmd_t      head,
    output logic      pop,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    localparam int HOLD_LIMIT = (HOLD_DEPTH < HOLD_STORE) ? HOLD_DEPTH : HOLD_STORE;
    localparam int HCNT_W     = $clog2(HOLD_LIMIT + 1);
    localparam int HIDX_W     = (HOLD_LIMIT > 1) ? $clog2(HOLD_LIMIT) : 1;

    logic [7:0]        held_mem [HOLD_LIMIT];
    phase_t            phase_reg, phase_next;
    logic [HCNT_W-1:0] fptr_reg, fptr_next;
    logic [HCNT_W-1:0] held_count_reg, held_count_next;
    logic              held_lost_reg, held_lost_next;
    logic              seen_text_reg, seen_text_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg;

    logic              adv;
    logic              emit;
    out_item_t         emit_item;
    logic              mem_we;
    logic [7:0]        held_rd;
    logic              ch_is_space;

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    assign adv         = !out_valid_reg || !result_stall;
    assign held_rd     = held_mem[fptr_reg[HIDX_W-1:0]];
    assign ch_is_space = is_space(head.ch);

    always_comb
    begin
        phase_next      = phase_reg;
        fptr_next       = fptr_reg;
        held_count_next = held_count_reg;
        held_lost_next  = held_lost_reg;
        seen_text_next  = seen_text_reg;
        pop             = 1'b0;
        emit            = 1'b0;
        mem_we          = 1'b0;
        emit_item       = '0;
        emit_item.space_overflow = held_lost_reg;

        if (head_valid && adv)
        begin
            unique case (phase_reg)
                PH_BODY:
                begin
                    emit_item.field_index    = head.idx;
                    emit_item.index_overflow = head.sat;
                    if (head.op_char && trim_enable && ch_is_space)
                    begin
                        // Whitespace: dropped before text or when full, else held.
                        if (seen_text_reg)
                        begin
                            if (held_count_reg < HCNT_W'(HOLD_LIMIT))
                            begin
                                mem_we          = 1'b1;
                                held_count_next = held_count_reg + 1'b1;
                            end
                            else
                            begin
                                held_lost_next = 1'b1;
                            end
                        end
                        if (head.eol)
                        begin
                            phase_next = PH_EOL;
                        end
                        else
                        begin
                            pop = 1'b1;
                        end
                    end
                    else if (head.op_char && (fptr_reg < held_count_reg))
                    begin
                        emit               = 1'b1;
                        emit_item.kind     = KIND_DATA;
                        emit_item.out_byte = held_rd;
                        fptr_next          = fptr_reg + 1'b1;
                    end
                    else if (head.op_char)
                    begin
                        emit                  = 1'b1;
                        emit_item.kind        = KIND_DATA;
                        emit_item.out_byte    = head.ch;
                        emit_item.last_of_run = !head.eol;
                        fptr_next             = '0;
                        held_count_next       = '0;
                        seen_text_next        = 1'b1;
                        if (head.eol)
                        begin
                            phase_next = PH_EOL;
                        end
                        else
                        begin
                            pop = 1'b1;
                        end
                    end
                    else if (head.op_comma)
                    begin
                        emit                  = 1'b1;
                        emit_item.kind        = KIND_MARK;
                        emit_item.last_of_run = !head.eol;
                        held_count_next       = '0;
                        held_lost_next        = 1'b0;
                        seen_text_next        = 1'b0;
                        if (head.eol)
                        begin
                            phase_next = PH_EOL;
                        end
                        else
                        begin
                            pop = 1'b1;
                        end
                    end
                    else
                    begin
                        emit                     = 1'b1;
                        emit_item.kind           = KIND_MARK;
                        emit_item.field_index    = head.eol_idx;
                        emit_item.index_overflow = head.eol_sat;
                        emit_item.line_end       = 1'b1;
                        emit_item.last_of_run    = 1'b1;
                        held_count_next          = '0;
                        held_lost_next           = 1'b0;
                        seen_text_next           = 1'b0;
                        pop                      = 1'b1;
                    end
                end
                PH_EOL:
                begin
                    emit                     = 1'b1;
                    emit_item.kind           = KIND_MARK;
                    emit_item.field_index    = head.eol_idx;
                    emit_item.index_overflow = head.eol_sat;
                    emit_item.line_end       = 1'b1;
                    emit_item.last_of_run    = 1'b1;
                    fptr_next                = '0;
                    held_count_next          = '0;
                    held_lost_next           = 1'b0;
                    seen_text_next           = 1'b0;
                    pop                      = 1'b1;
                    phase_next               = PH_BODY;
                end
                default:
                begin
                    phase_next = PH_BODY;
                end
            endcase
        end
    end

    assign out_valid_next = adv ? emit : out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            held_mem[held_count_reg[HIDX_W-1:0]] <= head.ch;
        end
        if (adv && emit)
        begin
            out_reg <= emit_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_BODY;
            fptr_reg       <= '0;
            held_count_reg <= '0;
            held_lost_reg  <= 1'b0;
            seen_text_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            fptr_reg       <= fptr_next;
            held_count_reg <= held_count_next;
            held_lost_reg  <= held_lost_next;
            seen_text_reg  <= seen_text_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// File: hw/rtl/csv_field_splitter_core.sv
// CSV field splitter, top level. A line enters one byte per input transaction;
// commas outside quotes split it into fields, and every field byte that is not
// trimmed leaves as a result tagged with its field index, followed by a field
// end marker, the last of which carries line_end. The front part takes one input
// transaction per cycle into a two-entry command queue. The back part drives a
// single output register and produces one result per cycle while result_stall
// is low. A plain field byte or comma yields one result, a byte that releases k
// held whitespace bytes yields k+1, a byte or comma that also ends the line
// yields one more, and whitespace that is held or dropped yields none. The input
// stalls only while the queue is full.
// trim_enable may be written only while the block is idle.
module csv_field_splitter_core
    import csvs_pkg::*;
#(
    parameter int MAX_FIELDS = MAX_FIELDS_DEF,
    parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      trim_wr_en,
    input  logic      trim_wr_data,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    // Trim configuration register; user must change it only while idle; unenforced.
    logic trim_enable_reg;

    // Command path between the front and the back parts.
    logic q_push;
    cmd_t q_cmd;
    logic q_full;
    logic q_pop;
    logic q_head_valid;
    cmd_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trim_enable_reg <= 1'b0;
        end
        else if (trim_wr_en)
        begin
            trim_enable_reg <= trim_wr_data;
        end
    end

    // The front part tracks quote mode and the field count, and classifies
    // each byte into a command for the back part.
    csvs_front #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_cmd)
    );

    csvs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    // The back part owns the whitespace hold buffer and the output register.
    csvs_back #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .trim_enable  (trim_enable_reg),
        .head_valid   (q_head_valid),
        .head         (q_head),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // The front never pushes a command into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_full))
        else $error("command pushed into a full queue");

    // The line end marker is always a marker and always the last result of its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.line_end) |->
            (result.kind == KIND_MARK) && result.last_of_run)
        else $error("line end result is not a closing marker");

    // Field end markers carry no character.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.kind == KIND_MARK)) |-> (result.out_byte == 8'h00))
        else $error("field end marker with a nonzero byte");

    // The queue is popped only when it holds a command.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_head_valid)
        else $error("command queue popped while empty");

endmodule

// File: verif/csv_field_splitter_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for csv_field_splitter_core: directed and random lines,
// predicted in-bench and compared transaction by transaction with the result port.
// Depends on csvs_pkg and the csv_field_splitter_core RTL.
module csv_field_splitter_core_tb;
    import csvs_pkg::*;

    // Bench sizing. The block is built with its default sizes, and the predictor uses
    // the same numbers. The hold buffer that matters is the smaller of the configured
    // depth and the physical store.
    localparam int HOLD_USABLE    = (HOLD_DEPTH_DEF < HOLD_STORE) ? HOLD_DEPTH_DEF : HOLD_STORE;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PRESSURE_HOLD  = 300;
    localparam int REPORT_LIMIT   = 10;

    // Clock, reset and every block input start at a known value at time zero.
    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      trim_wr_en   = 1'b0;
    logic      trim_wr_data = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_stall;
    in_item_t  item         = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;

    // Idling control, shared by the tests and the two sides of the bench.
    int max_gap       = 0;
    int max_hold      = 0;
    int pressure_req  = 0;

    // Run statistics and the failure count.
    int mismatches      = 0;
    int items_sent      = 0;
    int lines_sent      = 0;
    int results_checked = 0;
    int trim_writes     = 0;
    int saturated_seen  = 0;
    int dropped_seen    = 0;
    int idle_cycles     = 0;

    // Results the predictor expects, oldest first.
    out_item_t expected_tokens[$];
    // Results caused by the input transaction now being predicted.
    out_item_t step_results[$];
    // Bytes of the random line under construction.
    logic [7:0] line_bytes[$];

    // Predictor state: a private copy of the register and of the line state.
    logic       trim_on;
    logic       quoted;
    logic       after_quote;
    int         fld_count;
    logic       fld_sat;
    logic       got_text;
    logic [7:0] held_blanks[HOLD_STORE];
    int         held_n;
    logic       held_drop;

    csv_field_splitter_core #(
        .MAX_FIELDS (MAX_FIELDS_DEF),
        .HOLD_DEPTH (HOLD_DEPTH_DEF)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .trim_wr_en   (trim_wr_en),
        .trim_wr_data (trim_wr_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------------

    // Whitespace for trimming is the space character and the control bytes from tab
    // through carriage return.
    function automatic logic is_blank(logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // Queues one result for the current input transaction, tagged with the field
    // state as it stands right now.
    function automatic void emit(logic k, logic [7:0] b, logic lend);
        out_item_t r;
        r.kind           = k;
        r.out_byte       = b;
        r.field_index    = fld_count[FIDX_W-1:0];
        r.index_overflow = fld_sat;
        r.space_overflow = held_drop;
        r.line_end       = lend;
        r.last_of_run    = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic void clear_field_state();
        got_text  = 1'b0;
        held_n    = 0;
        held_drop = 1'b0;
    endfunction

    function automatic void clear_line_state();
        quoted      = 1'b0;
        after_quote = 1'b0;
        fld_count   = 0;
        fld_sat     = 1'b0;
        clear_field_state();
    endfunction

    // One character that belongs to the field. With trimming on, leading whitespace
    // vanishes and inner whitespace waits in the hold buffer until real text shows
    // that it was not trailing after all. Once the buffer is full, further
    // whitespace is dropped and the field carries the overflow flag from then on.
    function automatic void add_field_char(logic [7:0] c);
        if (trim_on && is_blank(c))
        begin
            if (got_text)
            begin
                if (held_n < HOLD_USABLE)
                begin
                    held_blanks[held_n] = c;
                    held_n++;
                end
                else
                    held_drop = 1'b1;
            end
        end
        else
        begin
            // Held bytes go out first; this also covers bytes that were held before
            // trimming was switched off in the middle of a line.
            for (int i = 0; i < held_n; i++)
                emit(KIND_DATA, held_blanks[i], 1'b0);
            held_n = 0;
            emit(KIND_DATA, c, 1'b0);
            got_text = 1'b1;
        end
    endfunction

    // Works out every result that one accepted input transaction causes and appends
    // them to the expected queue.
    function automatic void tokenize_item(in_item_t it);
        out_item_t r;
        step_results.delete();
        if (it.has_byte)
        begin
            if (!quoted && it.data_byte == CH_COMMA)
            begin
                // A comma outside quotes closes the field. At the last index the
                // counter sticks and the rest of the line is flagged.
                emit(KIND_MARK, 8'h00, 1'b0);
                clear_field_state();
                if (fld_count + 1 < MAX_FIELDS_DEF)
                    fld_count++;
                else
                    fld_sat = 1'b1;
                after_quote = 1'b0;
            end
            else if (it.data_byte != CH_QUOTE)
            begin
                add_field_char(it.data_byte);
                after_quote = 1'b0;
            end
            else if (quoted)
            begin
                quoted      = 1'b0;
                after_quote = 1'b1;
            end
            else
            begin
                // A quote that reopens quoting right after a closing quote is a
                // literal quote character.
                if (after_quote)
                    add_field_char(CH_QUOTE);
                quoted      = 1'b1;
                after_quote = 1'b1;
            end
        end
        if (it.end_of_line)
        begin
            // The final marker closes the line; an open quote is abandoned.
            emit(KIND_MARK, 8'h00, 1'b1);
            clear_line_state();
        end
        if (step_results.size() > 0)
        begin
            r = step_results[step_results.size() - 1];
            r.last_of_run = 1'b1;
            step_results[step_results.size() - 1] = r;
        end
        foreach (step_results[i])
        begin
            if (step_results[i].index_overflow)
                saturated_seen++;
            if (step_results[i].space_overflow)
                dropped_seen++;
            expected_tokens.push_back(step_results[i]);
        end
    endfunction

    // ------------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------------

    // Offers one input transaction after a random gap and returns at the clock edge
    // where it was accepted. Valid is left high so that a back-to-back transaction
    // does not lower and raise it within one time step; the next call, or the drain
    // task, takes it down.
    task automatic send_item(input in_item_t it);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        tokenize_item(it);
        if (it.has_byte || it.end_of_line)
            items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] c, input logic eol);
        in_item_t it;
        it.has_byte    = 1'b1;
        it.data_byte   = c;
        it.end_of_line = eol;
        send_item(it);
    endtask

    // A transaction without a byte; its data lane carries random junk.
    task automatic send_empty(input logic eol);
        in_item_t it;
        it.has_byte    = 1'b0;
        it.data_byte   = 8'($urandom_range(0, 255));
        it.end_of_line = eol;
        send_item(it);
    endtask

    task automatic send_text(input string s, input logic eol_at_end);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eol_at_end && (i == s.len() - 1));
    endtask

    // Takes valid down, waits for every expected result, then lets the block settle:
    // held whitespace and quotes produce no result, so an empty queue alone does not
    // prove the block is idle.
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes trim_enable while the block is idle. Line state survives the write.
    task automatic set_trim(input logic v);
        wait_drained();
        trim_wr_en   <= 1'b1;
        trim_wr_data <= v;
        @(posedge clk);
        trim_wr_en <= 1'b0;
        trim_on = v;
        trim_writes++;
    endtask

    // ------------------------------------------------------------------------------
    // Random line construction
    // ------------------------------------------------------------------------------

    // Printable text that is neither a comma nor a quote.
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        c = 8'($urandom_range(8'h21, 8'h7E));
        if (c == CH_COMMA || c == CH_QUOTE)
            c = c ^ 8'h40;
        return c;
    endfunction

    function automatic logic [7:0] blank_char();
        if ($urandom_range(0, 2) == 0)
            return CH_SPACE;
        return 8'($urandom_range(CH_TAB, CH_CR));
    endfunction

    // Whitespace run length; now and then long enough to overrun the hold buffer.
    function automatic int blank_run();
        if ($urandom_range(0, 5) == 0)
            return $urandom_range(HOLD_USABLE + 1, HOLD_USABLE + 4);
        return $urandom_range(1, 3);
    endfunction

    function automatic void add_plain(int n);
        for (int i = 0; i < n; i++)
            line_bytes.push_back(plain_char());
    endfunction

    function automatic void add_blanks(int n);
        for (int i = 0; i < n; i++)
            line_bytes.push_back(blank_char());
    endfunction

    // Builds and sends one line. Most fields are well formed: plain text, text
    // padded with whitespace, and quoted text holding commas and doubled quotes.
    // Some fields are raw noise over all byte values, which also yields unbalanced
    // quotes. One line in a dozen is wide enough that it can saturate the field index.
    task automatic send_random_line();
        int   nfields;
        int   style;
        int   noise_at;
        logic wide;
        logic sep_eol;
        line_bytes.delete();
        wide    = ($urandom_range(0, 11) == 0);
        nfields = wide ? $urandom_range(MAX_FIELDS_DEF - 4, MAX_FIELDS_DEF + 8)
                       : $urandom_range(1, 5);
        for (int f = 0; f < nfields; f++)
        begin
            if (f > 0)
                line_bytes.push_back(CH_COMMA);
            style = $urandom_range(0, 9);
            if (wide)
                add_plain($urandom_range(0, 1));
            else
            begin
                case (style)
                    0, 1, 2:
                        add_plain($urandom_range(1, 6));
                    3, 4:
                    begin
                        add_blanks($urandom_range(0, 3));
                        add_plain($urandom_range(1, 4));
                        add_blanks(blank_run());
                        add_plain($urandom_range(1, 3));
                        add_blanks(blank_run());
                    end
                    5, 6:
                    begin
                        add_blanks($urandom_range(0, 1));
                        line_bytes.push_back(CH_QUOTE);
                        add_plain($urandom_range(1, 3));
                        line_bytes.push_back(CH_COMMA);
                        add_blanks($urandom_range(0, 2));
                        line_bytes.push_back(CH_QUOTE);
                        line_bytes.push_back(CH_QUOTE);
                        add_plain($urandom_range(0, 2));
                        line_bytes.push_back(CH_QUOTE);
                        add_blanks($urandom_range(0, 2));
                    end
                    7:
                        ;
                    default:
                    begin
                        for (int i = $urandom_range(1, 5); i > 0; i--)
                            line_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                endcase
            end
        end
        // The line ends either on its last byte or on a separate byteless item.
        sep_eol  = (line_bytes.size() == 0) || ($urandom_range(0, 1) == 1);
        noise_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, line_bytes.size()) : -1;
        for (int i = 0; i < line_bytes.size(); i++)
        begin
            if (i == noise_at)
                send_empty(1'b0);
            send_byte(line_bytes[i], !sep_eol && (i == line_bytes.size() - 1));
        end
        if (sep_eol)
            send_empty(1'b1);
        lines_sent++;
    endtask

    task automatic run_random_lines(input int count);
        int start;
        start = items_sent;
        while (items_sent - start < count)
            send_random_line();
    endtask

    // ------------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------------

    // Plain fields with trimming off: a split line, an empty line, an item that
    // does nothing, and the extreme byte values.
    task automatic test_plain_fields();
        max_gap  = 3;
        max_hold = 3;
        send_text("ab,c", 1'b1);
        send_empty(1'b1);
        send_empty(1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_COMMA, 1'b1);
    endtask

    // Quoting: a comma inside quotes, a doubled quote that yields a literal quote,
    // and a closing quote on the byte that ends the line.
    task automatic test_quoted_fields();
        send_text("\"a,\"\",", 1'b0);
        send_byte(CH_QUOTE, 1'b1);
    endtask

    // Trimming: every whitespace byte, leading, inner and trailing.
    task automatic test_trim_edges();
        set_trim(1'b1);
        send_byte(CH_SPACE, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte("a", 1'b0);
        send_byte(8'h0B, 1'b0);
        send_byte(8'h0C, 1'b0);
        send_byte("b", 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(8'h0A, 1'b1);
    endtask

    // Whitespace held while trimming is on must come out ahead of the next byte
    // once trimming has been switched off in mid-line.
    task automatic test_trim_switch_mid_line();
        send_byte("a", 1'b0);
        send_byte(CH_SPACE, 1'b0);
        send_byte(CH_TAB, 1'b0);
        set_trim(1'b0);
        send_byte("b", 1'b1);
    endtask

    task automatic test_random_trim_off();
        set_trim(1'b0);
        max_gap  = 16;
        max_hold = 16;
        run_random_lines(130);
    endtask

    task automatic test_random_trim_on();
        set_trim(1'b1);
        max_gap  = 16;
        max_hold = 16;
        run_random_lines(130);
    endtask

    // The receiver holds off for a long stretch while the sender offers items
    // back to back, so the command queue fills and the input stalls.
    task automatic test_backpressure();
        max_gap      = 0;
        max_hold     = 4;
        pressure_req = PRESSURE_HOLD;
        run_random_lines(80);
    endtask

    // Full rate on both sides, with the trim setting flipped between chunks.
    task automatic test_random_no_idle();
        max_gap  = 0;
        max_hold = 0;
        for (int k = 0; k < 4; k++)
        begin
            set_trim(k[0]);
            run_random_lines(35);
        end
    endtask

    // ------------------------------------------------------------------------------
    // Output side: stalls at random and checks every accepted result transaction
    // against the oldest expectation.
    // ------------------------------------------------------------------------------
    initial
    begin : result_sink
        int        hold_left;
        int        pressure_left;
        out_item_t want;
        hold_left     = 0;
        pressure_left = 0;
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
            begin
                results_checked++;
                if (expected_tokens.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result: kind=%0b byte=%02h idx=%0d",
                                 result.kind, result.out_byte, result.field_index);
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (result.kind !== want.kind || result.out_byte !== want.out_byte ||
                        result.field_index !== want.field_index ||
                        result.index_overflow !== want.index_overflow ||
                        result.space_overflow !== want.space_overflow ||
                        result.line_end !== want.line_end ||
                        result.last_of_run !== want.last_of_run)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("result mismatch: expected kind=%0b byte=%02h idx=%0d ",
                                     want.kind, want.out_byte, want.field_index,
                                     "iov=%0b sov=%0b lend=%0b last=%0b; ",
                                     want.index_overflow, want.space_overflow,
                                     want.line_end, want.last_of_run,
                                     "actual kind=%0b byte=%02h idx=%0d ",
                                     result.kind, result.out_byte, result.field_index,
                                     "iov=%0b sov=%0b lend=%0b last=%0b",
                                     result.index_overflow, result.space_overflow,
                                     result.line_end, result.last_of_run);
                    end
                end
                hold_left = $urandom_range(0, max_hold);
            end
            // A long hold-off requested by a test is counted out here.
            if (pressure_req > 0)
            begin
                pressure_left = pressure_req;
                pressure_req  = 0;
            end
            if (pressure_left > 0)
            begin
                pressure_left--;
                result_stall <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // Watchdog: ends the run when neither channel has moved a transaction for too long.
    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // Test sequence.
    initial
    begin
        trim_on = 1'b0;
        clear_line_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_trim(1'b0);

        test_plain_fields();
        test_quoted_fields();
        test_trim_edges();
        test_trim_switch_mid_line();
        test_random_trim_off();
        test_random_trim_on();
        test_backpressure();
        test_random_no_idle();

        wait_drained();
        $display("covered %0d lines in %0d input transactions, %0d results, %0d trim writes",
                 lines_sent, items_sent, results_checked, trim_writes);
        $display("saturated-index results %0d, results after dropped whitespace %0d",
                 saturated_seen, dropped_seen);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
